/* rtl/core/thm_pkg.sv */
// Package for the thermal hotspot marker: widths, register indexes, coefficients,
// channel word types and the state encoding of the frame-end sequencer. No dependencies.
package thm_pkg;
	localparam int unsigned MAX_WIDTH_D  = 640;
	localparam int unsigned MAX_HEIGHT_D = 512;
	localparam int unsigned LUMA_W = 22;
	localparam int unsigned SUM_W  = 40;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLACK   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLAY = 2'd3;
	localparam logic [11:0] COEF_R = 12'd2126;
	localparam logic [12:0] COEF_G = 13'd7152;
	localparam logic [9:0]  COEF_B = 10'd722;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] value;
	} cfg_t;

	typedef struct packed {
		logic       overlay_valid;
		logic [9:0] center_col;
		logic [8:0] center_row;
		logic [6:0] ring_radius;
		logic [2:0] ring_stroke;
	} res_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_CHECK = 10'b0000000010,
		ST_SETUP = 10'b0000000100,
		ST_ADDR  = 10'b0000001000,
		ST_WAIT  = 10'b0000010000,
		ST_MUL   = 10'b0000100000,
		ST_TEST  = 10'b0001000000,
		ST_SQRT  = 10'b0010000000,
		ST_FIN   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;
endpackage

/* rtl/core/thm_stream_if.sv */
// Valid/ready channel interface with a parameterised payload type.
// Depends on nothing.
interface thm_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/thermal_hotspot_marker.sv */
// Top level of the thermal hotspot marker: pixel intake, luma store, peak
// tracking and the frame-end disk scan sequencer. Depends on thm_pkg,
// thm_stream_if, thm_ram and thm_mac.
//
//  channel  dir  payload                                       handshake
//  pix      in   red, green, blue                              valid/ready
//  res      out  overlay_valid, center_col/row, radius, stroke valid/ready
//  cfg      in   idx, value                                    valid/ready, always ready
//
// Pixels are taken back to back while idle; the last pixel of a frame starts the
// frame-end sequence, during which pix.ready is low. The sequence visits each pixel of
// the (2v+1)^2 square around the peak through the single RAM port, in the states
// WAIT, MUL and TEST for each pixel, then runs the square-root counter.
// Reset clears control state; the luma RAM is not cleared.
// The result waits in its register until taken; no pixel is taken meanwhile.
module thermal_hotspot_marker #(
	parameter int unsigned MAX_WIDTH  = thm_pkg::MAX_WIDTH_D,
	parameter int unsigned MAX_HEIGHT = thm_pkg::MAX_HEIGHT_D
) (
	input logic clk,
	input logic arst_n,
	thm_stream_if.sink   pix,
	thm_stream_if.sink   cfg,
	thm_stream_if.source res
);
	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = 24;
	localparam int unsigned LW = thm_pkg::LUMA_W;
	localparam int unsigned SW = thm_pkg::SUM_W;

	logic [9:0] width_q, height_q;
	logic       black_q, ovl_q;
	logic [CW-1:0] col_q, pk_col_q;
	logic [RW-1:0] row_q, pk_row_q;
	logic [LW-1:0] pk_luma_q;
	logic [SW-1:0] sum_q;
	thm_pkg::state_t st_q;
	logic [9:0] w_eff, h_eff, mind_q;
	logic [4:0] v_q;
	logic [3:0] pad_q;
	logic [7:0] hi_q;
	logic signed [13:0] dx_q, dy_q;
	logic [11:0] cnt_q;
	logic [12:0] bl_q, br_q, bt_q, bb_q;
	logic [13:0] ss_q;
	logic [7:0] root_q;
	logic [LW-1:0] mac_a;
	logic [LW+NW-1:0] prod_q;
	logic [LW-1:0] rdata;
	logic [AW-1:0] ram_addr;
	logic ram_we;
	logic [LW-1:0] luma;
	logic pix_fire, hot;
	logic signed [13:0] xs, ys;
	logic [NW-1:0] npix;
	logic [6:0] radius;
	logic [9:0] ocol;
	logic [8:0] orow;
	logic [2:0] stroke;
	logic out_v_q;
	logic [6:0] rad_q;

	assign w_eff = (width_q == 10'd0) ? 10'd1 :
		((32'(width_q) > MAX_WIDTH) ? 10'(MAX_WIDTH) : width_q);
	assign h_eff = (height_q == 10'd0) ? 10'd1 :
		((32'(height_q) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : height_q);
	assign npix = NW'(w_eff) * NW'(h_eff);
	assign luma = LW'(pix.data.red) * LW'(thm_pkg::COEF_R)
		+ LW'(pix.data.green) * LW'(thm_pkg::COEF_G)
		+ LW'(pix.data.blue) * LW'(thm_pkg::COEF_B);
	assign pix.ready = (st_q == thm_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign pix_fire = pix.valid && pix.ready;
	assign xs = 14'(pk_col_q) + dx_q;
	assign ys = 14'(pk_row_q) + dy_q;
	assign mac_a = (st_q == thm_pkg::ST_CHECK) ? pk_luma_q : rdata;
	assign hot = black_q ? (48'(prod_q) < 48'(sum_q)) : (48'(prod_q) > 48'(sum_q));

	thm_mac #(.AW(LW), .BW(NW)) u_mac (.clk(clk), .a(mac_a), .b(npix), .prod_q(prod_q));

	always_comb begin
		ram_we = pix_fire;
		ram_addr = AW'(32'(row_q) * MAX_WIDTH + 32'(col_q));
		if (!pix_fire) ram_addr = AW'(32'(ys[RW:0]) * MAX_WIDTH + 32'(xs[CW:0]));
	end

	thm_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_ram (.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(luma), .rdata(rdata));

	always_comb begin
		logic [7:0] base;
		base = 8'(root_q) + 8'(pad_q);
		if (base < 8'd8) radius = 7'd8;
		else if (base > hi_q) radius = 7'(hi_q);
		else radius = 7'(base);
		ocol = 10'((bl_q + br_q) >> 1);
		orow = 9'((bt_q + bb_q) >> 1);
		if (cnt_q >= 12'd72) stroke = 3'd5;
		else if (cnt_q >= 12'd48) stroke = 3'd4;
		else if (cnt_q >= 12'd24) stroke = 3'd3;
		else stroke = 3'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 10'(thm_pkg::MAX_WIDTH_D);
			height_q <= 10'(thm_pkg::MAX_HEIGHT_D);
			black_q <= 1'b0;
			ovl_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.data.idx)
				thm_pkg::REG_WIDTH:   width_q <= cfg.data.value;
				thm_pkg::REG_HEIGHT:  height_q <= cfg.data.value;
				thm_pkg::REG_BLACK:   black_q <= cfg.data.value[0];
				thm_pkg::REG_OVERLAY: ovl_q <= cfg.data.value[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= thm_pkg::ST_IDLE;
			col_q <= '0; row_q <= '0;
			pk_luma_q <= '0; pk_col_q <= '0; pk_row_q <= '0; sum_q <= '0;
			out_v_q <= 1'b0; res.valid <= 1'b0;
			cnt_q <= '0; dx_q <= '0; dy_q <= '0; ss_q <= '0; root_q <= '0;
			bl_q <= '0; br_q <= '0; bt_q <= '0; bb_q <= '0;
			v_q <= '0; pad_q <= '0; hi_q <= '0; mind_q <= '0; rad_q <= '0;
		end else begin
			unique case (st_q)
				thm_pkg::ST_IDLE: if (pix_fire) begin
					logic first;
					first = (col_q == '0) && (row_q == '0);
					sum_q <= first ? SW'(luma) : sum_q + SW'(luma);
					if (first || (black_q ? luma < pk_luma_q : luma > pk_luma_q)) begin
						pk_luma_q <= luma; pk_col_q <= col_q; pk_row_q <= row_q;
					end
					if (32'(col_q) + 1 < 32'(w_eff)) col_q <= col_q + 1'b1;
					else begin
						col_q <= '0;
						if (32'(row_q) + 1 < 32'(h_eff)) row_q <= row_q + 1'b1;
						else begin
							row_q <= '0;
							st_q <= thm_pkg::ST_CHECK;
						end
					end
				end
				thm_pkg::ST_CHECK: begin
					mind_q <= (w_eff < h_eff) ? w_eff : h_eff;
					st_q <= thm_pkg::ST_SETUP;
				end
				thm_pkg::ST_SETUP: begin
					logic [14:0] x28, x8;
					logic [30:0] q28, q8;
					logic [23:0] q5;
					x28 = 15'(mind_q) * 15'd28 + 15'd500;
					x8 = 15'(mind_q) * 15'd8 + 15'd500;
					q28 = (31'(x28) * 31'd33555) >> 25;
					q8 = (31'(x8) * 31'd33555) >> 25;
					q5 = (24'(mind_q) * 24'd13108) >> 16;
					v_q <= (q28 < 31'd10) ? 5'd10 : ((q28 > 31'd24) ? 5'd24 : 5'(q28));
					pad_q <= (q8 < 31'd4) ? 4'd4 : ((q8 > 31'd8) ? 4'd8 : 4'(q8));
					hi_q <= 8'(q5);
					bl_q <= 13'(pk_col_q); br_q <= 13'(pk_col_q);
					bt_q <= 13'(pk_row_q); bb_q <= 13'(pk_row_q);
					cnt_q <= '0;
					dx_q <= -14'sd24; dy_q <= -14'sd24;
					if (!ovl_q || !hot) begin
						out_v_q <= 1'b0; st_q <= thm_pkg::ST_OUT; res.valid <= 1'b1;
					end else st_q <= thm_pkg::ST_ADDR;
				end
				thm_pkg::ST_ADDR: begin
					if (dx_q < -$signed({9'd0, v_q})) dx_q <= -$signed({9'd0, v_q});
					else if (dy_q < -$signed({9'd0, v_q})) dy_q <= -$signed({9'd0, v_q});
					else st_q <= thm_pkg::ST_WAIT;
				end
				thm_pkg::ST_WAIT: st_q <= thm_pkg::ST_MUL;
				thm_pkg::ST_MUL: st_q <= thm_pkg::ST_TEST;
				thm_pkg::ST_TEST: begin
					if (xs >= 0 && ys >= 0 && xs < 14'(w_eff) && ys < 14'(h_eff)
						&& dx_q * dx_q + dy_q * dy_q <= 14'(v_q) * 14'(v_q) && hot) begin
						cnt_q <= cnt_q + 1'b1;
						if (13'(xs) < bl_q) bl_q <= 13'(xs);
						if (13'(xs) > br_q) br_q <= 13'(xs);
						if (13'(ys) < bt_q) bt_q <= 13'(ys);
						if (13'(ys) > bb_q) bb_q <= 13'(ys);
					end
					if (dx_q < $signed({9'd0, v_q})) begin
						dx_q <= dx_q + 1'b1; st_q <= thm_pkg::ST_WAIT;
					end else if (dy_q < $signed({9'd0, v_q})) begin
						dx_q <= -$signed({9'd0, v_q}); dy_q <= dy_q + 1'b1;
						st_q <= thm_pkg::ST_WAIT;
					end else begin
						root_q <= '0; st_q <= thm_pkg::ST_FIN;
					end
				end
				thm_pkg::ST_FIN: begin
					logic [13:0] hw, hh;
					hw = 14'((br_q - bl_q + 13'd1) >> 1);
					hh = 14'((bb_q - bt_q + 13'd1) >> 1);
					ss_q <= hw * hw + hh * hh;
					st_q <= thm_pkg::ST_SQRT;
				end
				thm_pkg::ST_SQRT: begin
					if (16'(root_q) * 16'(root_q) < 16'(ss_q)) root_q <= root_q + 1'b1;
					else begin
						rad_q <= radius; out_v_q <= 1'b1; res.valid <= 1'b1;
						st_q <= thm_pkg::ST_OUT;
					end
				end
				thm_pkg::ST_OUT: if (res.ready) begin
					res.valid <= 1'b0; st_q <= thm_pkg::ST_IDLE;
				end
				default: st_q <= thm_pkg::ST_IDLE;
			endcase
		end
	end

	assign res.data.overlay_valid = out_v_q;
	assign res.data.center_col = out_v_q ? ocol : '0;
	assign res.data.center_row = out_v_q ? orow : '0;
	assign res.data.ring_radius = out_v_q ? rad_q : '0;
	assign res.data.ring_stroke = out_v_q ? stroke : '0;
endmodule

/* rtl/core/thm_ram.sv */
// Generic single-port RAM with registered read.
// Depends on nothing.
module thm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

/* rtl/core/thm_mac.sv */
// Shared multiply unit: a registered product a*b, used for every luma-times-count
// compare against the luma sum. Depends on nothing.
module thm_mac #(
	parameter int unsigned AW = 22,
	parameter int unsigned BW = 24
) (
	input  logic                        clk,
	input  logic [AW-1:0]               a,
	input  logic [BW-1:0]               b,
	output logic [AW+BW-1:0]            prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
endmodule

/* rtl/core/thm_checker.sv */
// Port-level checker for the thermal hotspot marker, bound to the top level.
// Depends on nothing beyond the top level it is bound to.
module thm_checker (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	input logic pix_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_ov,
	input logic [2:0] res_stroke
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) res_valid |-> !pix_ready)
		else $error("pixel taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid) else $error("result dropped");
	a_strk: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ov |-> res_stroke >= 3'd2 && res_stroke <= 3'd5)
		else $error("stroke out of range");
endmodule

bind thermal_hotspot_marker thm_checker u_chk (.clk(clk), .arst_n(arst_n),
	.pix_valid(pix.valid), .pix_ready(pix.ready), .res_valid(res.valid),
	.res_ready(res.ready), .res_ov(res.data.overlay_valid),
	.res_stroke(res.data.ring_stroke));

/* test/thermal_hotspot_marker_tb.sv */
// Testbench for thermal_hotspot_marker: drives frames of RGB pixels, writes the
// size and mode registers between frames and checks every frame result against
// a luma/hotspot predictor. Depends on thm_pkg, thm_stream_if and the RTL.
`timescale 1ns / 100ps

module thermal_hotspot_marker_tb;
	typedef struct {
		int              w;
		int              h;
		bit              bh;
		bit              ov;
		thm_pkg::pix_t   p;
		bit              typed;
		thm_pkg::res_t   r;
	} row_t;

	localparam int MW = thm_pkg::MAX_WIDTH_D;
	localparam int MH = thm_pkg::MAX_HEIGHT_D;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;

	thm_stream_if #(.payload_t(thm_pkg::pix_t)) pix_ch (clk);
	thm_stream_if #(.payload_t(thm_pkg::cfg_t)) cfg_ch (clk);
	thm_stream_if #(.payload_t(thm_pkg::res_t)) res_ch (clk);

	thermal_hotspot_marker uut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch),
		.cfg(cfg_ch),
		.res(res_ch)
	);

	// predictor state
	logic [9:0]  reg_w = 10'd640;
	logic [9:0]  reg_h = 10'd512;
	bit          reg_bh = 1'b0;
	bit          reg_ov = 1'b1;
	logic [21:0] luma_mem [0:MW*MH-1];
	logic [39:0] luma_acc;
	logic [21:0] peak_l;
	int          peak_c, peak_r, pos_c, pos_r;

	thm_pkg::res_t frame_results_q[$];
	int   mismatches = 0;
	int   results_seen = 0;
	int   pixels_sent = 0;
	int   idle_cycles = 0;
	bit   steady = 0;
	bit   hold_req = 0;
	bit   typed_next = 0;
	thm_pkg::res_t typed_val;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int eff_dim(logic [9:0] v, int maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic int clamp_lo_first(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic bit above_mean(logic [21:0] l, longint unsigned npix);
		longint unsigned scaled;
		scaled = longint'(l) * npix;
		return reg_bh ? (scaled < luma_acc) : (scaled > luma_acc);
	endfunction

	function automatic thm_pkg::res_t close_frame(int w, int h);
		longint unsigned npix;
		int   min_dim, v, pad, rad, hw, hh, content, l, r, t, b, cnt, dx, dy;
		thm_pkg::res_t o;
		npix = longint'(w) * longint'(h);
		o = '0;
		if (!reg_ov || !above_mean(peak_l, npix)) return o;
		min_dim = (w < h) ? w : h;
		v = clamp_lo_first((min_dim * 28 + 500) / 1000, 10, 24);
		l = peak_c; r = peak_c; t = peak_r; b = peak_r;
		cnt = 0;
		for (int y = peak_r - v; y <= peak_r + v; y++) begin
			if (y < 0 || y >= h) continue;
			for (int x = peak_c - v; x <= peak_c + v; x++) begin
				if (x < 0 || x >= w) continue;
				dx = x - peak_c;
				dy = y - peak_r;
				if (dx * dx + dy * dy > v * v) continue;
				if (!above_mean(luma_mem[y * MW + x], npix)) continue;
				cnt = (cnt + 1) & 12'hFFF;
				if (x < l) l = x;
				if (x > r) r = x;
				if (y < t) t = y;
				if (y > b) b = y;
			end
		end
		hw = (r - l + 1) / 2;
		hh = (b - t + 1) / 2;
		content = 0;
		while (content * content < hw * hw + hh * hh) content++;
		pad = clamp_lo_first((min_dim * 8 + 500) / 1000, 4, 8);
		rad = clamp_lo_first(content + pad, 8, min_dim / 5);
		o.overlay_valid = 1'b1;
		o.center_col = 10'((l + r) / 2);
		o.center_row = 9'((t + b) / 2);
		o.ring_radius = 7'(rad);
		o.ring_stroke = 3'(clamp_lo_first(2 + cnt / 24, 2, 5));
		return o;
	endfunction

	function automatic void ingest_pixel(thm_pkg::pix_t p);
		int          w, h;
		logic [21:0] l;
		bit          first, take;
		thm_pkg::res_t o;
		w = eff_dim(reg_w, MW);
		h = eff_dim(reg_h, MH);
		l = 22'(2126 * p.red + 7152 * p.green + 722 * p.blue);
		first = (pos_c == 0 && pos_r == 0);
		if (pos_c >= MW) pos_c = MW - 1;
		if (pos_r >= MH) pos_r = MH - 1;
		luma_mem[pos_r * MW + pos_c] = l;
		luma_acc = first ? 40'(l) : luma_acc + 40'(l);
		take = first || (reg_bh ? (l < peak_l) : (l > peak_l));
		if (take) begin
			peak_l = l;
			peak_c = pos_c;
			peak_r = pos_r;
		end
		if (pos_c + 1 < w) begin
			pos_c++;
			return;
		end
		pos_c = 0;
		if (pos_r + 1 < h) begin
			pos_r++;
			return;
		end
		pos_r = 0;
		o = close_frame(w, h);
		frame_results_q.push_back(typed_next ? typed_val : o);
	endfunction

	// monitor: predict on accepted pixels, compare accepted results
	always @(posedge clk) begin
		thm_pkg::res_t want;
		thm_pkg::res_t got;
		if (pix_ch.valid && pix_ch.ready)
			ingest_pixel(pix_ch.data);
		if (res_ch.valid && res_ch.ready) begin
			got = res_ch.data;
			results_seen++;
			if (frame_results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %p", got);
			end else begin
				want = frame_results_q.pop_front();
				if (got.overlay_valid !== want.overlay_valid ||
						got.center_col !== want.center_col ||
						got.center_row !== want.center_row ||
						got.ring_radius !== want.ring_radius ||
						got.ring_stroke !== want.ring_stroke) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %p, got %p",
							results_seen, want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// result side: random stalls, one long hold-off to back up the pixel input
	initial begin
		int gap;
		res_ch.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				gap = 600;
			end else
				gap = steady ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	task automatic send_pixel(thm_pkg::pix_t p);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.data <= p;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic write_reg(logic [thm_pkg::CFG_IDX_W-1:0] idx, logic [9:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{idx: idx, value: value};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			thm_pkg::REG_WIDTH:   reg_w = value;
			thm_pkg::REG_HEIGHT:  reg_h = value;
			thm_pkg::REG_BLACK:   reg_bh = value[0];
			thm_pkg::REG_OVERLAY: reg_ov = value[0];
			default: ;
		endcase
	endtask

	task automatic settle();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (frame_results_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(int w, int h, bit bh, bit ov);
		if (reg_w != 10'(w) || reg_h != 10'(h) || reg_bh != bh || reg_ov != ov) begin
			settle();
			if (reg_w != 10'(w)) write_reg(thm_pkg::REG_WIDTH, 10'(w));
			if (reg_h != 10'(h)) write_reg(thm_pkg::REG_HEIGHT, 10'(h));
			if (reg_bh != bh) write_reg(thm_pkg::REG_BLACK, 10'(bh));
			if (reg_ov != ov) write_reg(thm_pkg::REG_OVERLAY, 10'(ov));
		end
	endtask

	function automatic thm_pkg::pix_t rand_pix();
		return thm_pkg::pix_t'($urandom_range(0, 24'hFFFFFF));
	endfunction

	task automatic random_frame(int w, int h, bit bh, bit ov);
		int   ew, eh, mode, bc, br, rr, lvl;
		thm_pkg::pix_t p;
		set_mode(w, h, bh, ov);
		steady = ($urandom_range(0, 3) == 0);
		ew = eff_dim(10'(w), MW);
		eh = eff_dim(10'(h), MH);
		mode = $urandom_range(0, 5);
		bc = $urandom_range(0, ew - 1);
		br = $urandom_range(0, eh - 1);
		rr = $urandom_range(0, 4);
		lvl = $urandom_range(0, 255);
		for (int y = 0; y < eh; y++)
			for (int x = 0; x < ew; x++) begin
				if (mode == 0) p = '{8'(lvl), 8'(lvl), 8'(lvl)};
				else if (mode == 1) p = rand_pix();
				else if ((x - bc) * (x - bc) + (y - br) * (y - br) <= rr * rr) begin
					p = rand_pix();
					p.green = bh ? 8'($urandom_range(0, 40)) : 8'($urandom_range(200, 255));
				end else begin
					p = rand_pix();
					p.green = bh ? 8'($urandom_range(120, 255)) : 8'($urandom_range(0, 90));
				end
				send_pixel(p);
			end
	endtask

	row_t dir_rows[$];

	initial begin
		row_t rw;
		int   n, w, h, left;
		arst_n = 1'b0;
		pix_ch.valid <= 1'b0;
		pix_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		luma_acc = '0;
		peak_l = '0;
		peak_c = 0; peak_r = 0; pos_c = 0; pos_r = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-pixel frames: never hotter than their own mean
		for (int i = 0; i < 8; i++) begin
			rw = '{w: 1, h: 1, bh: 0, ov: 1, typed: 1, r: '0,
				p: '{i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00, i[2] ? 8'hFF : 8'h00}};
			dir_rows.push_back(rw);
		end
		for (int i = 0; i < 9; i++) begin
			rw = '{w: 3, h: 3, bh: 0, ov: 1, typed: 0, r: '0,
				p: (i == 4) ? 24'hFFFFFF : 24'h102030};
			dir_rows.push_back(rw);
		end
		// overlay disabled: blank result whatever the content
		for (int i = 0; i < 4; i++) begin
			rw = '{w: 2, h: 2, bh: 1, ov: 0, typed: 1, r: '0,
				p: (i == 0) ? 24'h000000 : 24'hFFFFFF};
			dir_rows.push_back(rw);
		end
		for (int i = 0; i < 4; i++) begin
			rw = '{w: 2, h: 2, bh: 1, ov: 1, typed: 0, r: '0,
				p: (i == 3) ? 24'h000000 : 24'hC0C0C0};
			dir_rows.push_back(rw);
		end
		write_reg(thm_pkg::REG_OVERLAY, 10'd1);
		write_reg(thm_pkg::REG_BLACK, 10'd0);
		left = 0;
		foreach (dir_rows[i]) begin
			rw = dir_rows[i];
			if (left == 0) begin
				settle();
				set_mode(rw.w, rw.h, rw.bh, rw.ov);
				left = eff_dim(10'(rw.w), MW) * eff_dim(10'(rw.h), MH);
			end
			typed_val = rw.r;
			typed_next = rw.typed;
			send_pixel(rw.p);
			left--;
		end
		settle();
		typed_next = 0;

		// out-of-range sizes and a frame narrower than the disk
		random_frame(0, 5, 0, 1);
		random_frame(7, 0, 1, 1);
		random_frame(11, 10, 0, 1);

		// same-mode burst: the long hold-off stalls the pixel input
		hold_req = 1'b1;
		for (int i = 0; i < 4; i++)
			random_frame(3, 3, 0, 1);

		n = 0;
		while (pixels_sent < 470) begin
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 9);
			random_frame(w, h, $urandom_range(0, 1), $urandom_range(0, 7) != 0);
			n++;
		end
		random_frame(10, 8, 0, 1);
		settle();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && frame_results_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* sim.f */
rtl/core/thm_pkg.sv
rtl/core/thm_stream_if.sv
rtl/core/thm_ram.sv
rtl/core/thm_mac.sv
rtl/core/thermal_hotspot_marker.sv
rtl/core/thm_checker.sv
test/thermal_hotspot_marker_tb.sv
